[sv/whbh_pkg.sv]
// Shared types, constants and helper functions for the word hash bucket histogram.
package whbh_pkg;

  localparam int HASH_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int NB_W     = 15;
  localparam int BUCKET_W = 14;
  localparam int COUNT_W  = 24;
  localparam int WORDS_W  = 32;
  localparam int SQUARE_W = 48;
  localparam int STEP_W   = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] HASH_SEED    = 32'hC965AF37;
  localparam logic [HASH_W-1:0] LO_BYTE_MASK = 32'h000000FF;
  localparam logic [HASH_W-1:0] HI_MASK      = 32'hFFFE0000;

  localparam logic [NB_W-1:0]    NB_RESET  = 15'd16384;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;

  typedef struct packed {
    logic [BYTE_W-1:0] char_byte;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [HASH_W-1:0]   hash_value;
    logic [BUCKET_W-1:0] bucket;
    logic [COUNT_W-1:0]  bucket_count;
    logic [WORDS_W-1:0]  words_seen;
    logic [SQUARE_W-1:0] sum_of_squares;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_UPDATE
  } state_t;

  // space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] hi;
    logic [HASH_W-1:0] mid;
    logic [HASH_W-1:0] lo;
    hi  = (h << 9) & HI_MASK;
    mid = ((h & LO_BYTE_MASK) ^ {{(HASH_W-BYTE_W){1'b0}}, b}) << 9;
    lo  = h >> 23;
    return hi | mid | lo;
  endfunction

endpackage

[sv/word_hash_bucket_histogram_core.sv]
// Word hash bucket histogram: bytes in, one result per finished word out.
// After reset the bucket store is cleared one entry a cycle with in_ready low
// (configuration writes are still taken). A byte that does not end a word is taken
// in the idle state, which it does not leave. A byte that ends a word is accepted, then the
// remainder hash mod num_buckets is worked one bit a cycle through a single shared
// compare-and-subtract, then the bucket RAM is read, then the read-modify-write and
// result load follow; that step also waits while the previous result is still held.
// The next byte can be taken while a result waits on out_ready.
module word_hash_bucket_histogram_core
  import whbh_pkg::*;
#(
  parameter int MAX_BUCKETS = 16384
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [NB_W-1:0]     cfg_wdata
);

  localparam int DW = $clog2(MAX_BUCKETS + 1);
  localparam int AW = $clog2(MAX_BUCKETS);

  state_t state, state_next;

  logic [NB_W-1:0]     num_buckets;
  logic [HASH_W-1:0]   running_hash;
  logic                in_word;
  logic [WORDS_W-1:0]  word_total;
  logic [SQUARE_W-1:0] square_total;
  logic [AW-1:0]       clr_addr;
  out_item_t           out_item;

  logic [HASH_W-1:0] word_hash;
  logic [HASH_W-1:0] quo;
  logic [DW-1:0]     rem;
  logic [STEP_W-1:0] step;

  logic              accept;
  logic              byte_space;
  logic [HASH_W-1:0] mixed;
  logic              finish;
  logic [HASH_W-1:0] finish_hash;
  logic              out_free;

  logic [DW-1:0] div_eff;
  logic [DW:0]   trial;
  logic [DW:0]   trial_sub;
  logic          trial_ge;
  logic [DW-1:0] rem_next;

  logic [COUNT_W-1:0]  cnt_old;
  logic                cnt_sat;
  logic [COUNT_W-1:0]  cnt_new;
  logic [SQUARE_W:0]   sq_sum;
  logic [SQUARE_W-1:0] square_total_next;
  logic [WORDS_W-1:0]  word_total_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [COUNT_W-1:0] ram_rdata_w;

  assign accept      = in_valid && in_ready;
  assign byte_space  = is_space(in_data.char_byte);
  assign mixed       = mix_byte(running_hash, in_data.char_byte);
  assign finish      = byte_space ? in_word : in_data.end_of_text;
  assign finish_hash = byte_space ? running_hash : mixed;
  assign out_free    = !out_valid || out_ready;

  // divisor clamped to 1..MAX_BUCKETS
  always_comb begin
    if (num_buckets == '0) begin
      div_eff = DW'(1);
    end else if (32'(num_buckets) > 32'(MAX_BUCKETS)) begin
      div_eff = DW'(MAX_BUCKETS);
    end else begin
      div_eff = DW'(num_buckets);
    end
  end

  // one restoring remainder step
  always_comb begin
    trial     = {rem, quo[HASH_W-1]};
    trial_sub = trial - {1'b0, div_eff};
    trial_ge  = trial >= {1'b0, div_eff};
    rem_next  = trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
  end

  always_comb begin
    cnt_old = ram_rdata_w;
    cnt_sat = (cnt_old == COUNT_MAX);
    cnt_new = cnt_sat ? cnt_old : cnt_old + COUNT_W'(1);
    // (c+1)^2 - c^2 = 2c+1
    sq_sum  = {1'b0, square_total} + (SQUARE_W + 1)'({cnt_old, 1'b1});
    if (cnt_sat) begin
      square_total_next = square_total;
    end else if (sq_sum[SQUARE_W]) begin
      square_total_next = '1;
    end else begin
      square_total_next = sq_sum[SQUARE_W-1:0];
    end
    word_total_next = (&word_total) ? word_total : word_total + WORDS_W'(1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(MAX_BUCKETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && finish) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step == STEP_W'(HASH_W - 1)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(rem);
    ram_wdata = cnt_new;
    ram_re    = 1'b0;
    ram_raddr = AW'(rem);
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_UPDATE: begin
        ram_we = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      num_buckets  <= NB_RESET;
      running_hash <= HASH_SEED;
      in_word      <= 1'b0;
      word_total   <= '0;
      square_total <= '0;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        num_buckets <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            if (finish) begin
              running_hash <= HASH_SEED;
              in_word      <= 1'b0;
            end else if (!byte_space) begin
              running_hash <= mixed;
              in_word      <= 1'b1;
            end
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            word_total   <= word_total_next;
            square_total <= square_total_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        word_hash <= finish_hash;
        quo       <= finish_hash;
        rem       <= '0;
        step      <= '0;
      end
      ST_DIVIDE: begin
        rem  <= rem_next;
        quo  <= quo << 1;
        step <= step + STEP_W'(1);
      end
      ST_UPDATE: begin
        if (out_free) begin
          out_item.hash_value     <= word_hash;
          out_item.bucket         <= BUCKET_W'(rem);
          out_item.bucket_count   <= cnt_new;
          out_item.words_seen     <= word_total_next;
          out_item.sum_of_squares <= square_total_next;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_data = out_item;

  whbh_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(MAX_BUCKETS)
  ) u_counts (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata_w)
  );

endmodule

[sv/whbh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module whbh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[tb/word_hash_bucket_histogram_core_tb.sv]
// Testbench for the word hash bucket histogram core: random text stream, word-level checks.
`timescale 1ns / 100ps

module word_hash_bucket_histogram_core_tb;
  import whbh_pkg::*;

  localparam int N_BUCKETS = 16384;
  localparam int N_PHASES  = 8;
  localparam int SETTLE    = 50;

  class bucket_word_tracker;
    logic [NB_W-1:0]     nb_reg;
    logic [HASH_W-1:0]   hash_acc;
    bit                  in_word;
    logic [COUNT_W-1:0]  counts [N_BUCKETS];
    logic [WORDS_W-1:0]  word_tot;
    logic [SQUARE_W-1:0] square_tot;
    out_item_t           pending_words [$];
    int                  errors;

    function new();
      nb_reg     = NB_RESET;
      hash_acc   = HASH_SEED;
      in_word    = 1'b0;
      word_tot   = '0;
      square_tot = '0;
      errors     = 0;
      foreach (counts[i]) counts[i] = '0;
    endfunction

    static function bit is_blank(logic [BYTE_W-1:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function void set_buckets(logic [NB_W-1:0] v);
      nb_reg = v;
    endfunction

    function void close_word();
      int                  divisor;
      int                  slot;
      logic [SQUARE_W-1:0] step;
      out_item_t           w;
      divisor = (nb_reg == 0) ? 1 : ((nb_reg > N_BUCKETS) ? N_BUCKETS : int'(nb_reg));
      slot = int'(hash_acc % divisor);
      if (counts[slot] != COUNT_MAX) begin
        // (c+1)^2 - c^2
        step = {23'd0, counts[slot], 1'b1};
        counts[slot] = counts[slot] + 1'b1;
        square_tot = (square_tot > ({SQUARE_W{1'b1}} - step)) ? {SQUARE_W{1'b1}}
                                                             : square_tot + step;
      end
      if (word_tot != {WORDS_W{1'b1}}) word_tot = word_tot + 1'b1;
      w.hash_value     = hash_acc;
      w.bucket         = slot[BUCKET_W-1:0];
      w.bucket_count   = counts[slot];
      w.words_seen     = word_tot;
      w.sum_of_squares = square_tot;
      pending_words.push_back(w);
      hash_acc = HASH_SEED;
      in_word  = 1'b0;
    endfunction

    function void note_byte(in_item_t it);
      if (is_blank(it.char_byte)) begin
        if (in_word) close_word();
      end else begin
        hash_acc = {hash_acc[22:8], hash_acc[7:0] ^ it.char_byte, hash_acc[31:23]};
        in_word  = 1'b1;
        if (it.end_of_text) close_word();
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(out_item_t got);
      out_item_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("result with none pending, hash %h", got.hash_value));
        return;
      end
      want = pending_words.pop_front();
      if (got.hash_value !== want.hash_value)
        report($sformatf("hash_value %h, want %h", got.hash_value, want.hash_value));
      if (got.bucket !== want.bucket)
        report($sformatf("bucket %0d, want %0d", got.bucket, want.bucket));
      if (got.bucket_count !== want.bucket_count)
        report($sformatf("bucket_count %0d, want %0d", got.bucket_count, want.bucket_count));
      if (got.words_seen !== want.words_seen)
        report($sformatf("words_seen %0d, want %0d", got.words_seen, want.words_seen));
      if (got.sum_of_squares !== want.sum_of_squares)
        report($sformatf("sum_of_squares %0d, want %0d", got.sum_of_squares,
                         want.sum_of_squares));
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_data;
  logic            cfg_we = 1'b0;
  logic [NB_W-1:0] cfg_wdata = NB_RESET;

  int send_idle = 0;
  int recv_idle = 0;

  bucket_word_tracker hist;

  logic [BYTE_W-1:0] dict_bytes [8][8];
  int                dict_len [8];

  // divisor per phase: reset value, a small odd count, zero (acts as one), above the
  // maximum, one, just above the maximum, two, just below the maximum
  logic [NB_W-1:0] bucket_plan [N_PHASES] =
    '{15'd16384, 15'd7, 15'd0, 15'd32767, 15'd1, 15'd16385, 15'd2, 15'd16383};

  // space with nothing pending, zero and 0xFF as word bytes, every blank as a word end,
  // neighbours of the blank range, end of text alone and on a blank
  logic [8:0] directed_seq [21] = '{
    {8'd32, 1'b0}, {8'd0, 1'b0}, {8'd255, 1'b0}, {8'd9, 1'b0}, {8'd8, 1'b0},
    {8'd14, 1'b0}, {8'd10, 1'b0}, {8'd31, 1'b0}, {8'd33, 1'b0}, {8'd11, 1'b0},
    {8'd128, 1'b0}, {8'd12, 1'b0}, {8'd127, 1'b0}, {8'd13, 1'b0}, {8'd65, 1'b1},
    {8'd32, 1'b1}, {8'd65, 1'b0}, {8'd32, 1'b1}, {8'd66, 1'b0}, {8'd67, 1'b1},
    {8'd65, 1'b1}
  };

  word_hash_bucket_histogram_core #(
    .MAX_BUCKETS(N_BUCKETS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) hist.check_word(out_data);
  end

  task automatic drive_byte(input in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    hist.note_byte(it);
    @(negedge clk);
  endtask

  task automatic write_buckets(input logic [NB_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    hist.set_buckets(v);
  endtask

  task automatic drain();
    while (hist.pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic send_blanks(input int n);
    in_item_t it;
    int       pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(5);
      it.char_byte   = (pick == 5) ? CH_SPACE : CH_TAB + pick[BYTE_W-1:0];
      it.end_of_text = ($urandom_range(9) == 0);
      drive_byte(it);
    end
  endtask

  task automatic run_text(input int quota);
    int                sent;
    int                len;
    int                pick;
    logic [BYTE_W-1:0] b;
    in_item_t          it;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 80) begin
        // a word, half the time a repeat from the dictionary so buckets fill up
        pick = $urandom_range(15);
        if (pick < 8) len = dict_len[pick];
        else len = ($urandom_range(9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          if (pick < 8) b = dict_bytes[pick][k];
          else do b = BYTE_W'($urandom_range(255));
               while (bucket_word_tracker::is_blank(b));
          it.char_byte   = b;
          it.end_of_text = (k == len - 1) && ($urandom_range(99) < 15);
          drive_byte(it);
          sent++;
        end
        if (!it.end_of_text) begin
          len = $urandom_range(1, 3);
          send_blanks(len);
          sent += len;
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          it.char_byte   = BYTE_W'($urandom_range(255));
          it.end_of_text = ($urandom_range(3) == 0);
          drive_byte(it);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] b;
    hist = new();
    for (int w = 0; w < 8; w++) begin
      dict_len[w] = $urandom_range(1, 8);
      for (int k = 0; k < 8; k++) begin
        do b = BYTE_W'($urandom_range(255)); while (bucket_word_tracker::is_blank(b));
        dict_bytes[w][k] = b;
      end
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 3)
        0: begin
          send_idle = 37;
          recv_idle = 83;
        end
        1: begin
          send_idle = 83;
          recv_idle = 37;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      write_buckets(bucket_plan[p]);
      if (p == 0) begin
        foreach (directed_seq[i]) drive_byte(in_item_t'(directed_seq[i]));
      end
      run_text(135);
      in_valid <= 1'b0;
      drain();
    end
    if (hist.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
